// ----- design/q2h_pkg.sv -----
`default_nettype none

package q2h_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int CORDIC_STAGES   = 16;
  localparam int FRAC_BITS       = COMPONENT_WIDTH - 1;
  localparam int THR_WIDTH       = 15;
  localparam int ANGLE_WIDTH     = 16;
  localparam int ACC_WIDTH       = 32;
  localparam int PROD_WIDTH      = 2 * COMPONENT_WIDTH;
  // Room for the sums of products and for CORDIC gain on a vector below 2^30.
  localparam int VEC_WIDTH       = (PROD_WIDTH + 2 > 34) ? PROD_WIDTH + 2 : 34;
  localparam int SHIFT_WIDTH     = $clog2(VEC_WIDTH);
  localparam int NORM_MSB        = 29;
  localparam int THR_SHIFT       = 2 * FRAC_BITS - THR_WIDTH;

  localparam int FRONT_STAGES    = 3;
  localparam int NORM_STAGES     = 4;
  localparam int PIPE_DEPTH      = FRONT_STAGES + NORM_STAGES + CORDIC_STAGES + 1;
  localparam int CNT_WIDTH       = $clog2(PIPE_DEPTH + 1);

  localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(16351);

  localparam logic [ACC_WIDTH-1:0] ANGLE_QUARTER = 32'h4000_0000;
  localparam logic [ACC_WIDTH-1:0] ANGLE_3QUARTER = 32'hC000_0000;
  localparam logic [ACC_WIDTH-1:0] ROUND_BIAS =
    ACC_WIDTH'(1) << (ACC_WIDTH - ANGLE_WIDTH - 1);
  localparam logic [CNT_WIDTH-1:0] PIPE_DEPTH_C = CNT_WIDTH'(PIPE_DEPTH);

  typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
  typedef logic signed [PROD_WIDTH-1:0]      prod_t;
  typedef logic signed [VEC_WIDTH-1:0]       vec_t;

  localparam vec_t NORMAL_ONE = vec_t'(1) << (2 * FRAC_BITS - 2);

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_t;

  typedef struct packed {
    comp_t quat_x;
    comp_t quat_y;
    comp_t quat_z;
    comp_t quat_w;
  } in_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] heading_angle;
    logic [1:0]                    pole_case;
  } out_t;

  // atan2 operands: vy over vx
  typedef struct packed {
    vec_t  vx;
    vec_t  vy;
    pole_t pole;
  } vec_pair_t;

  typedef struct packed {
    vec_t                 vx;
    vec_t                 vy;
    logic [ACC_WIDTH-1:0] acc;
    pole_t                pole;
    logic                 zero;
  } rot_t;

  // atan(2^-i) in 2^32 counts per turn
  function automatic logic [ACC_WIDTH-1:0] atan_entry(input int unsigned idx);
    logic [ACC_WIDTH-1:0] val;
    case (idx)
      0:       val = 32'd536870912;
      1:       val = 32'd316933406;
      2:       val = 32'd167458907;
      3:       val = 32'd85004756;
      4:       val = 32'd42667331;
      5:       val = 32'd21354465;
      6:       val = 32'd10679838;
      7:       val = 32'd5340245;
      8:       val = 32'd2670163;
      9:       val = 32'd1335087;
      10:      val = 32'd667544;
      11:      val = 32'd333772;
      12:      val = 32'd166886;
      13:      val = 32'd83443;
      14:      val = 32'd41722;
      15:      val = 32'd20861;
      16:      val = 32'd10430;
      17:      val = 32'd5215;
      18:      val = 32'd2608;
      19:      val = 32'd1304;
      20:      val = 32'd652;
      21:      val = 32'd326;
      22:      val = 32'd163;
      23:      val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- design/quaternion_to_heading.sv -----
`default_nettype none

// Quaternion to heading. Each item is a unit quaternion (x, y, z, w, signed Q1.15);
// the result is the heading as a 16-bit binary angle (32768 counts = pi, wrapped to
// [-pi, pi)) and a pole code (0 normal, 1 north, 2 south). The pole test x*y + z*w
// is compared against pole_threshold (Q0.15, reset 0.499), written through cfg_we /
// cfg_wdata; the user must write it only while no item is in flight, which the block
// does not enforce. Throughput is one item per clock while the output is not stalled.
// Stages: 3 product/select, 4 normalization, one per CORDIC iteration (16), each with
// its own register, and the output register. A stall holds every full stage; empty
// stages fill behind a stalled output, so up to 24 items can be in flight.
module quaternion_to_heading (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  q2h_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output q2h_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [q2h_pkg::THR_WIDTH-1:0] cfg_wdata
);

  logic [q2h_pkg::THR_WIDTH-1:0] thr_r;
  logic                          front_ready;
  logic                          front_valid, norm_ready;
  q2h_pkg::vec_pair_t            front_vec;
  logic                          norm_valid, cordic_ready;
  q2h_pkg::rot_t                 norm_rot;
  logic                          cordic_valid, out_ready;
  q2h_pkg::rot_t                 cordic_rot;
  q2h_pkg::out_t                 out_r, out_nxt;
  logic                          out_valid_r;
  logic [q2h_pkg::CNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                          in_fire, out_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= q2h_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  q2h_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .in_data   (in_data),
    .thr       (thr_r),
    .out_valid (front_valid),
    .out_ready (norm_ready),
    .out_vec   (front_vec)
  );

  q2h_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (norm_ready),
    .in_vec    (front_vec),
    .out_valid (norm_valid),
    .out_ready (cordic_ready),
    .out_rot   (norm_rot)
  );

  q2h_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (norm_valid),
    .in_ready  (cordic_ready),
    .in_rot    (norm_rot),
    .out_valid (cordic_valid),
    .out_ready (out_ready),
    .out_rot   (cordic_rot)
  );

  assign in_stall  = !front_ready;
  assign out_ready = !out_valid_r || !out_stall;

  // Double for the pole cases, negate for south, round half up to 16 bits.
  // South uses ~2a + bias + 1 so one adder covers negate and round.
  always_comb begin
    logic [q2h_pkg::ACC_WIDTH-1:0] dbl, h_pre, bias, h_sum;
    dbl = {cordic_rot.acc[q2h_pkg::ACC_WIDTH-2:0], 1'b0};
    case (cordic_rot.pole)
      q2h_pkg::POLE_NORTH: begin
        h_pre = dbl;
        bias  = q2h_pkg::ROUND_BIAS;
      end
      q2h_pkg::POLE_SOUTH: begin
        h_pre = ~dbl;
        bias  = q2h_pkg::ROUND_BIAS + q2h_pkg::ACC_WIDTH'(1);
      end
      default: begin
        h_pre = cordic_rot.acc;
        bias  = q2h_pkg::ROUND_BIAS;
      end
    endcase
    if (cordic_rot.zero) begin
      h_pre = '0;
      bias  = q2h_pkg::ROUND_BIAS;
    end
    h_sum = h_pre + bias;
    out_nxt.heading_angle = h_sum[q2h_pkg::ACC_WIDTH-1 -: q2h_pkg::ANGLE_WIDTH];
    out_nxt.pole_case     = cordic_rot.pole;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= cordic_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Items in flight, for checking only
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire && !out_fire) begin
      cnt_nxt = cnt_r + q2h_pkg::CNT_WIDTH'(1);
    end else if (!in_fire && out_fire) begin
      cnt_nxt = cnt_r - q2h_pkg::CNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // An empty output register lets every stage advance, so nothing backs up to the input
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= q2h_pkg::PIPE_DEPTH_C)
    else $error("more items in flight than pipeline stages");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result shown with no item in flight");

endmodule

`default_nettype wire

// ----- design/q2h_front.sv -----
`default_nettype none

module q2h_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  q2h_pkg::in_t                   in_data,
  input  logic [q2h_pkg::THR_WIDTH-1:0]  thr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output q2h_pkg::vec_pair_t             out_vec
);

  typedef struct packed {
    q2h_pkg::prod_t prod_xy;
    q2h_pkg::prod_t prod_zw;
    q2h_pkg::prod_t prod_yw;
    q2h_pkg::prod_t prod_xz;
    q2h_pkg::prod_t prod_yy;
    q2h_pkg::prod_t prod_zz;
    q2h_pkg::comp_t qx;
    q2h_pkg::comp_t qw;
  } prod_set_t;

  typedef struct packed {
    q2h_pkg::vec_t  t;
    q2h_pkg::vec_t  num;
    q2h_pkg::vec_t  den;
    q2h_pkg::comp_t qx;
    q2h_pkg::comp_t qw;
  } sum_set_t;

  prod_set_t          s1_r, s1_nxt;
  sum_set_t           s2_r, s2_nxt;
  q2h_pkg::vec_pair_t s3_r, s3_nxt;
  logic               v1_r, v2_r, v3_r;
  logic               rdy1, rdy2, rdy3;
  q2h_pkg::vec_t      t_cmp, thr_cmp;
  logic               north, south;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Stage 1: all products
  always_comb begin
    q2h_pkg::comp_t qx, qy, qz, qw;
    qx = in_data.quat_x;
    qy = in_data.quat_y;
    qz = in_data.quat_z;
    qw = in_data.quat_w;
    s1_nxt.prod_xy = qx * qy;
    s1_nxt.prod_zw = qz * qw;
    s1_nxt.prod_yw = qy * qw;
    s1_nxt.prod_xz = qx * qz;
    s1_nxt.prod_yy = qy * qy;
    s1_nxt.prod_zz = qz * qz;
    s1_nxt.qx      = qx;
    s1_nxt.qw      = qw;
  end

  // Stage 2: pole test sum, numerator and denominator
  always_comb begin
    q2h_pkg::prod_t pxy, pzw, pyw, pxz, pyy, pzz;
    q2h_pkg::vec_t  exy, ezw, eyw, exz, eyy, ezz;
    pxy = s1_r.prod_xy;
    pzw = s1_r.prod_zw;
    pyw = s1_r.prod_yw;
    pxz = s1_r.prod_xz;
    pyy = s1_r.prod_yy;
    pzz = s1_r.prod_zz;
    exy = q2h_pkg::vec_t'(pxy);
    ezw = q2h_pkg::vec_t'(pzw);
    eyw = q2h_pkg::vec_t'(pyw);
    exz = q2h_pkg::vec_t'(pxz);
    eyy = q2h_pkg::vec_t'(pyy);
    ezz = q2h_pkg::vec_t'(pzz);
    s2_nxt.t   = exy + ezw;
    s2_nxt.num = ((eyw >>> 2) - (exz >>> 2)) <<< 1;
    s2_nxt.den = q2h_pkg::NORMAL_ONE - (((eyy >>> 2) + (ezz >>> 2)) <<< 1);
    s2_nxt.qx  = s1_r.qx;
    s2_nxt.qw  = s1_r.qw;
  end

  // Align the threshold with the product scale
  if (q2h_pkg::THR_SHIFT >= 0) begin : g_thr_up
    assign t_cmp   = s2_r.t;
    assign thr_cmp = q2h_pkg::vec_t'(thr) << q2h_pkg::THR_SHIFT;
  end else begin : g_thr_down
    assign t_cmp   = s2_r.t <<< (-q2h_pkg::THR_SHIFT);
    assign thr_cmp = q2h_pkg::vec_t'(thr);
  end

  assign north = t_cmp > thr_cmp;
  assign south = t_cmp < -thr_cmp;

  // Stage 3: pick the atan2 operands
  always_comb begin
    q2h_pkg::comp_t qx, qw;
    qx = s2_r.qx;
    qw = s2_r.qw;
    if (north) begin
      s3_nxt.pole = q2h_pkg::POLE_NORTH;
      s3_nxt.vy   = q2h_pkg::vec_t'(qx);
      s3_nxt.vx   = q2h_pkg::vec_t'(qw);
    end else if (south) begin
      s3_nxt.pole = q2h_pkg::POLE_SOUTH;
      s3_nxt.vy   = q2h_pkg::vec_t'(qx);
      s3_nxt.vx   = q2h_pkg::vec_t'(qw);
    end else begin
      s3_nxt.pole = q2h_pkg::POLE_NONE;
      s3_nxt.vy   = s2_r.num;
      s3_nxt.vx   = s2_r.den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
  end

  assign out_valid = v3_r;
  assign out_vec   = s3_r;

endmodule

`default_nettype wire

// ----- design/q2h_norm.sv -----
`default_nettype none

module q2h_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  q2h_pkg::vec_pair_t in_vec,
  output logic               out_valid,
  input  logic               out_ready,
  output q2h_pkg::rot_t      out_rot
);

  typedef struct packed {
    q2h_pkg::vec_t                 vx;
    q2h_pkg::vec_t                 vy;
    logic [q2h_pkg::VEC_WIDTH-1:0] mag;
    q2h_pkg::pole_t                pole;
  } mag_set_t;

  typedef struct packed {
    q2h_pkg::vec_t                   vx;
    q2h_pkg::vec_t                   vy;
    logic [q2h_pkg::SHIFT_WIDTH-1:0] shl;
    logic [q2h_pkg::SHIFT_WIDTH-1:0] shr;
    logic                            zero;
    q2h_pkg::pole_t                  pole;
  } shift_set_t;

  typedef struct packed {
    q2h_pkg::vec_t  vx;
    q2h_pkg::vec_t  vy;
    logic           zero;
    q2h_pkg::pole_t pole;
  } scaled_set_t;

  mag_set_t      sa_r, sa_nxt;
  shift_set_t    sb_r, sb_nxt;
  scaled_set_t   sc_r, sc_nxt;
  q2h_pkg::rot_t sd_r, sd_nxt;
  logic          va_r, vb_r, vc_r, vd_r;
  logic          rdya, rdyb, rdyc, rdyd;

  assign rdyd     = !vd_r || out_ready;
  assign rdyc     = !vc_r || rdyd;
  assign rdyb     = !vb_r || rdyc;
  assign rdya     = !va_r || rdyb;
  assign in_ready = rdya;

  // Stage A: larger magnitude of the two operands
  always_comb begin
    q2h_pkg::vec_t                 vx, vy;
    logic [q2h_pkg::VEC_WIDTH-1:0] ax, ay;
    vx = in_vec.vx;
    vy = in_vec.vy;
    ax = vx[q2h_pkg::VEC_WIDTH-1] ? -vx : vx;
    ay = vy[q2h_pkg::VEC_WIDTH-1] ? -vy : vy;
    sa_nxt.vx   = vx;
    sa_nxt.vy   = vy;
    sa_nxt.mag  = (ax > ay) ? ax : ay;
    sa_nxt.pole = in_vec.pole;
  end

  // Stage B: leading one search, shift toward the normalization window
  always_comb begin
    logic [q2h_pkg::SHIFT_WIDTH-1:0] pos;
    pos = '0;
    for (int i = 0; i < q2h_pkg::VEC_WIDTH; i++) begin
      if (sa_r.mag[i]) pos = q2h_pkg::SHIFT_WIDTH'(i);
    end
    sb_nxt.vx   = sa_r.vx;
    sb_nxt.vy   = sa_r.vy;
    sb_nxt.pole = sa_r.pole;
    sb_nxt.zero = (sa_r.mag == '0);
    sb_nxt.shl  = '0;
    sb_nxt.shr  = '0;
    if (pos < q2h_pkg::SHIFT_WIDTH'(q2h_pkg::NORM_MSB)) begin
      sb_nxt.shl = q2h_pkg::SHIFT_WIDTH'(q2h_pkg::NORM_MSB) - pos;
    end else begin
      sb_nxt.shr = pos - q2h_pkg::SHIFT_WIDTH'(q2h_pkg::NORM_MSB);
    end
  end

  // Stage C: apply the common shift (floor on the way down)
  always_comb begin
    q2h_pkg::vec_t vx, vy;
    vx = sb_r.vx;
    vy = sb_r.vy;
    if (sb_r.shr != '0) begin
      sc_nxt.vx = vx >>> sb_r.shr;
      sc_nxt.vy = vy >>> sb_r.shr;
    end else begin
      sc_nxt.vx = vx <<< sb_r.shl;
      sc_nxt.vy = vy <<< sb_r.shl;
    end
    sc_nxt.zero = sb_r.zero;
    sc_nxt.pole = sb_r.pole;
  end

  // Stage D: fold the left half plane into the right one
  always_comb begin
    q2h_pkg::vec_t vx, vy;
    vx = sc_r.vx;
    vy = sc_r.vy;
    sd_nxt.zero = sc_r.zero;
    sd_nxt.pole = sc_r.pole;
    if (!vx[q2h_pkg::VEC_WIDTH-1]) begin
      sd_nxt.vx  = vx;
      sd_nxt.vy  = vy;
      sd_nxt.acc = '0;
    end else if (!vy[q2h_pkg::VEC_WIDTH-1]) begin
      sd_nxt.vx  = vy;
      sd_nxt.vy  = -vx;
      sd_nxt.acc = q2h_pkg::ANGLE_QUARTER;
    end else begin
      sd_nxt.vx  = -vy;
      sd_nxt.vy  = vx;
      sd_nxt.acc = q2h_pkg::ANGLE_3QUARTER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdya) va_r <= in_valid;
      if (rdyb) vb_r <= va_r;
      if (rdyc) vc_r <= vb_r;
      if (rdyd) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdya) sa_r <= sa_nxt;
    if (rdyb) sb_r <= sb_nxt;
    if (rdyc) sc_r <= sc_nxt;
    if (rdyd) sd_r <= sd_nxt;
  end

  assign out_valid = vd_r;
  assign out_rot   = sd_r;

endmodule

`default_nettype wire

// ----- design/q2h_cordic.sv -----
`default_nettype none

module q2h_cordic (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  q2h_pkg::rot_t in_rot,
  output logic          out_valid,
  input  logic          out_ready,
  output q2h_pkg::rot_t out_rot
);

  localparam int N = q2h_pkg::CORDIC_STAGES;

  q2h_pkg::rot_t stage_in [N+1];
  logic          stage_v  [N+1];
  logic          rdy      [N+1];
  q2h_pkg::rot_t st_r     [N];
  q2h_pkg::rot_t st_nxt   [N];
  logic          v_r      [N];

  assign stage_in[0] = in_rot;
  assign stage_v[0]  = in_valid;
  assign rdy[N]      = out_ready;
  assign in_ready    = rdy[0];

  for (genvar i = 0; i < N; i++) begin : g_iter
    assign rdy[i] = !v_r[i] || rdy[i+1];

    // One micro-rotation toward the x axis
    always_comb begin
      q2h_pkg::vec_t vx, vy, xs, ys;
      vx = stage_in[i].vx;
      vy = stage_in[i].vy;
      xs = vx >>> i;
      ys = vy >>> i;
      st_nxt[i].pole = stage_in[i].pole;
      st_nxt[i].zero = stage_in[i].zero;
      if (!vy[q2h_pkg::VEC_WIDTH-1]) begin
        st_nxt[i].vx  = vx + ys;
        st_nxt[i].vy  = vy - xs;
        st_nxt[i].acc = stage_in[i].acc + q2h_pkg::atan_entry(i);
      end else begin
        st_nxt[i].vx  = vx - ys;
        st_nxt[i].vy  = vy + xs;
        st_nxt[i].acc = stage_in[i].acc - q2h_pkg::atan_entry(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= stage_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) st_r[i] <= st_nxt[i];
    end

    assign stage_in[i+1] = st_r[i];
    assign stage_v[i+1]  = v_r[i];
  end

  assign out_valid = stage_v[N];
  assign out_rot   = stage_in[N];

endmodule

`default_nettype wire

// ----- verif/quaternion_to_heading_chk.sv -----
`default_nettype none

module quaternion_to_heading_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  q2h_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  q2h_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [q2h_pkg::THR_WIDTH-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  import q2h_pkg::*;

  localparam int FRAC      = COMPONENT_WIDTH - 1;
  localparam int THR_ALIGN = 2 * FRAC - THR_WIDTH;
  localparam int MAX_LINES = 100;

  // atan(2^-i), one turn = 2^32
  localparam logic [31:0] ARCTAN_STEP [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  logic [THR_WIDTH-1:0] threshold;
  out_t                 heading_q [$];
  out_t                 want;
  int                   errors = 0;

  assign fail_count = errors;

  // atan2(vy, vx) as a 32-bit binary angle
  function automatic logic [31:0] cordic_angle(input longint vy_in, input longint vx_in);
    longint      vx, vy, xs, ys, big, tmp;
    int          dn, up;
    logic [31:0] acc;
    vx  = vx_in;
    vy  = vy_in;
    acc = '0;
    dn  = 0;
    up  = 0;
    if (vx == 0 && vy == 0) return '0;
    big = (vx < 0) ? -vx : vx;
    tmp = (vy < 0) ? -vy : vy;
    if (tmp > big) big = tmp;
    while (big >= (longint'(1) << 30)) begin
      big = big >> 1;
      dn++;
    end
    while (big < (longint'(1) << 29)) begin
      big = big << 1;
      up++;
    end
    if (dn > 0) begin
      vx = vx >>> dn;
      vy = vy >>> dn;
    end else if (up > 0) begin
      vx = vx * (longint'(1) << up);
      vy = vy * (longint'(1) << up);
    end
    // fold the left half-plane by a quarter turn
    if (vx < 0) begin
      tmp = vx;
      if (vy >= 0) begin
        vx  = vy;
        vy  = -tmp;
        acc = 32'h4000_0000;
      end else begin
        vx  = -vy;
        vy  = tmp;
        acc = 32'hC000_0000;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx  = vx + ys;
        vy  = vy - xs;
        acc = acc + ARCTAN_STEP[i];
      end else begin
        vx  = vx - ys;
        vy  = vy + xs;
        acc = acc - ARCTAN_STEP[i];
      end
    end
    return acc;
  endfunction

  function automatic out_t predict_heading(input in_t q, input logic [THR_WIDTH-1:0] thr);
    longint      qx, qy, qz, qw, pa, pb, thr_s, num, den, one;
    logic [31:0] h, rounded;
    out_t        res;
    qx    = longint'(q.quat_x);
    qy    = longint'(q.quat_y);
    qz    = longint'(q.quat_z);
    qw    = longint'(q.quat_w);
    pa    = qx * qy;
    pb    = qz * qw;
    thr_s = longint'(thr) << THR_ALIGN;
    if (pa > thr_s - pb) begin
      h             = cordic_angle(qx, qw) << 1;
      res.pole_case = POLE_NORTH;
    end else if (pa < -thr_s - pb) begin
      h             = 32'd0 - (cordic_angle(qx, qw) << 1);
      res.pole_case = POLE_SOUTH;
    end else begin
      one           = longint'(1) << (2 * FRAC - 2);
      num           = 2 * (((qy * qw) >>> 2) - ((qx * qz) >>> 2));
      den           = one - 2 * (((qy * qy) >>> 2) + ((qz * qz) >>> 2));
      h             = cordic_angle(num, den);
      res.pole_case = POLE_NONE;
    end
    rounded           = h + 32'h0000_8000;
    res.heading_angle = rounded[31:16];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < MAX_LINES) $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      threshold = THR_RESET;
      heading_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (heading_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: heading %0d pole %0d",
                                    out_data.heading_angle, out_data.pole_case));
        end else begin
          want = heading_q.pop_front();
          if (out_data.heading_angle !== want.heading_angle)
            report_mismatch($sformatf("heading_angle got %0d, want %0d",
                                      out_data.heading_angle, want.heading_angle));
          if (out_data.pole_case !== want.pole_case)
            report_mismatch($sformatf("pole_case got %0d, want %0d",
                                      out_data.pole_case, want.pole_case));
        end
      end
      if (in_valid && !in_stall) heading_q.push_back(predict_heading(in_data, threshold));
      if (cfg_we) threshold = cfg_wdata;
    end
    waiting <= heading_q.size();
  end

endmodule

`default_nettype wire

// ----- verif/quaternion_to_heading_tb.sv -----
`default_nettype none

module quaternion_to_heading_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import q2h_pkg::*;

  localparam int N_SEGMENTS   = 6;
  localparam int SEG_ITEMS    = 283;
  localparam int N_DIRECTED   = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = PIPE_DEPTH + 8;

  localparam int EDGE_VALS [8] = '{-32768, -32767, -1, 0, 1, 16384, -16384, 32767};

  // x, y, z, w
  localparam int DIRECTED [N_DIRECTED][4] = '{
    '{0, 0, 0, 0},                          // zero quaternion
    '{0, 0, 0, 32767},                      // identity
    '{0, 0, 32767, 0},                      // heading of pi
    '{0, 16384, 16384, 0},                  // atan2 of the zero vector
    '{16384, 16384, 16384, 16384},          // north pole
    '{16384, -16384, 16384, -16384},        // south pole
    '{-16384, -16384, -16384, -16384},      // north, doubled angle wraps
    '{-16384, 16384, 16384, -16384},        // south, doubled angle wraps
    '{-32768, -32768, -32768, -32768},
    '{32767, 32767, 32767, 32767},
    '{-32768, 32767, -32768, 32767},
    '{32767, -32768, 0, 0},
    '{0, 0, -32768, -32768},
    '{-32768, 0, 0, 0},
    '{0, -32768, 0, 0},
    '{0, 23170, 0, 23170},
    '{0, 0, 23170, 23170},
    '{23170, 0, 0, -23170},
    '{1, -1, 1, -1},
    '{-1, 1, -1, 1}
  };

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [THR_WIDTH-1:0] cfg_wdata = '0;

  int fail_count;
  int waiting;
  int cycle_count  = 0;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  quaternion_to_heading i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  quaternion_to_heading_chk i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_t unit_quat();
    real r [4];
    real n;
    in_t q;
    n = 0.0;
    for (int k = 0; k < 4; k++) begin
      r[k] = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
      n    = n + r[k] * r[k];
    end
    if (n < 1.0e-6) begin
      r[3] = 1.0;
      n    = 1.0;
    end
    n        = $sqrt(n);
    q.quat_x = comp_t'($rtoi(r[0] / n * 32767.0));
    q.quat_y = comp_t'($rtoi(r[1] / n * 32767.0));
    q.quat_z = comp_t'($rtoi(r[2] / n * 32767.0));
    q.quat_w = comp_t'($rtoi(r[3] / n * 32767.0));
    return q;
  endfunction

  // x*y + z*w lands close to +-0.5 on a unit quaternion
  function automatic in_t near_pole_quat();
    real c, th;
    int  px, pw, sgn;
    in_t q;
    c   = 0.70710678 * (1.0 + (real'($urandom_range(0, 2000)) - 1000.0) / 100000.0);
    th  = real'($urandom_range(0, 6283)) / 1000.0;
    px  = $rtoi(c * $cos(th) * 32767.0);
    pw  = $rtoi(c * $sin(th) * 32767.0);
    sgn = $urandom_range(0, 1) ? -1 : 1;
    q.quat_x = comp_t'(sgn * px + int'($urandom_range(0, 40)) - 20);
    q.quat_w = comp_t'(sgn * pw + int'($urandom_range(0, 40)) - 20);
    if ($urandom_range(0, 1)) begin
      q.quat_y = comp_t'(sgn * px);
      q.quat_z = comp_t'(sgn * pw);
    end else begin
      q.quat_y = comp_t'(-sgn * px);
      q.quat_z = comp_t'(-sgn * pw);
    end
    return q;
  endfunction

  function automatic in_t random_quat();
    in_t q;
    case ($urandom_range(0, 9))
      0, 1, 2: q = in_t'({$urandom, $urandom});
      3, 4, 5: q = unit_quat();
      6, 7, 8: q = near_pole_quat();
      default: begin
        q.quat_x = comp_t'(EDGE_VALS[$urandom_range(0, 7)]);
        q.quat_y = comp_t'(EDGE_VALS[$urandom_range(0, 7)]);
        q.quat_z = comp_t'(EDGE_VALS[$urandom_range(0, 7)]);
        q.quat_w = comp_t'(EDGE_VALS[$urandom_range(0, 7)]);
      end
    endcase
    return q;
  endfunction

  task automatic send_quat(input in_t q);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender until every pending item has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_WIDTH-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [THR_WIDTH-1:0] seg_thr [N_SEGMENTS];
    in_t                  q;
    seg_thr = '{THR_RESET, '0, '1, THR_WIDTH'($urandom_range(0, 32767)),
                THR_WIDTH'(1), THR_WIDTH'($urandom_range(0, 32767))};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int s = 0; s < N_SEGMENTS; s++) begin
      case (s / 2)
        0: begin
          in_idle_pct  = 14;
          out_idle_pct = 63;
        end
        1: begin
          in_idle_pct  = 63;
          out_idle_pct = 14;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      if (s > 0) drain();
      write_threshold(seg_thr[s]);
      if (s == 0) begin
        for (int d = 0; d < N_DIRECTED; d++) begin
          q.quat_x = comp_t'(DIRECTED[d][0]);
          q.quat_y = comp_t'(DIRECTED[d][1]);
          q.quat_z = comp_t'(DIRECTED[d][2]);
          q.quat_w = comp_t'(DIRECTED[d][3]);
          send_quat(q);
        end
      end
      for (int n = 0; n < SEG_ITEMS; n++) send_quat(random_quat());
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/q2h_pkg.sv
design/q2h_front.sv
design/q2h_norm.sv
design/q2h_cordic.sv
design/quaternion_to_heading.sv
verif/quaternion_to_heading_chk.sv
verif/quaternion_to_heading_tb.sv
